@@ src/lps_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lps_pkg: shared types and constants for the line point stepper
// Field widths, command codes, step directions and the queued operation
// format that the front and back halves exchange.
// ----------------------------------------------------------------------------
package lps_pkg;

    localparam int COORD_W     = 10;
    localparam int COLOR_W     = 16;
    // Error accumulators and the point counter need one bit above a coordinate.
    localparam int ERR_W       = COORD_W + 1;
    localparam int CNT_W       = COORD_W + 1;
    localparam int QUEUE_DEPTH = 4;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_STEP = 1'b1;

    typedef enum logic [1:0] {
        DIR_NONE  = 2'd0,
        DIR_PLUS  = 2'd1,
        DIR_MINUS = 2'd3
    } dir_t;

    typedef struct packed {
        logic               cmd;
        logic [COORD_W-1:0] x_start;
        logic [COORD_W-1:0] y_start;
        logic [COORD_W-1:0] x_end;
        logic [COORD_W-1:0] y_end;
        logic [COLOR_W-1:0] pixel_color;
    } cmd_item_t;

    typedef struct packed {
        logic [COORD_W-1:0] point_x;
        logic [COORD_W-1:0] point_y;
        logic [COLOR_W-1:0] pix_color;
        logic               last_point;
    } pix_item_t;

    // One classified operation waiting for the stepper.
    typedef struct packed {
        logic               is_load;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] abs_dcol;
        logic [COORD_W-1:0] abs_drow;
        logic [COORD_W-1:0] major;
        dir_t               dir_col;
        dir_t               dir_row;
        logic [COLOR_W-1:0] color;
    } lps_op_t;

    // Queue handshake between front and back.
    typedef struct packed {
        logic full;
        logic empty;
    } lps_qstat_t;

endpackage
`default_nettype wire

@@ src/line_point_stepper_core.sv @@
`default_nettype none
// A step transaction passes through a queue slot and then the pixel output register.
// Throughput: one command transaction per cycle, loads and steps alike, while the
// queue is not full; the queue absorbs output stalls.
// Reset: asynchronous and active low; it empties the queue, drops any line in
// progress and clears the output valid. No clearing pass is needed.
// ----------------------------------------------------------------------------
// line_point_stepper_core: error-accumulation line drawing engine
// Front half classifies and sets up commands, a short queue decouples it from
// the back half, which steps the line and drives the pixel stream.
// ----------------------------------------------------------------------------
module line_point_stepper_core #(
    parameter int QUEUE_DEPTH = lps_pkg::QUEUE_DEPTH
) (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   cmd_valid,
    output logic                  cmd_stall,
    input  lps_pkg::cmd_item_t    cmd_item,
    output logic                  pix_valid,
    input  wire                   pix_stall,
    output lps_pkg::pix_item_t    pix_item
);
    import lps_pkg::*;

    lps_qstat_t qstat;
    lps_op_t    push_op;
    lps_op_t    head_op;
    logic       push;
    logic       pop;

    lps_front u_front (
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_item  (cmd_item),
        .qstat     (qstat),
        .push      (push),
        .push_op   (push_op)
    );

    lps_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_op (push_op),
        .pop     (pop),
        .head_op (head_op),
        .qstat   (qstat)
    );

    lps_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_op   (head_op),
        .qstat     (qstat),
        .pop       (pop),
        .pix_valid (pix_valid),
        .pix_stall (pix_stall),
        .pix_item  (pix_item)
    );

endmodule
`default_nettype wire

@@ src/lps_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lps_front: command intake and line setup
// Accepts command transactions, classifies them and, for loads, works out
// the absolute deltas, step directions and major-axis distance.
// ----------------------------------------------------------------------------
module lps_front (
    input  wire                   cmd_valid,
    output logic                  cmd_stall,
    input  lps_pkg::cmd_item_t    cmd_item,
    input  lps_pkg::lps_qstat_t   qstat,
    output logic                  push,
    output lps_pkg::lps_op_t      push_op
);
    import lps_pkg::*;

    logic [COORD_W-1:0] dcol;
    logic [COORD_W-1:0] drow;
    dir_t               dir_col;
    dir_t               dir_row;

    always_comb
    begin
        if (cmd_item.x_end > cmd_item.x_start)
        begin
            dcol    = cmd_item.x_end - cmd_item.x_start;
            dir_col = DIR_PLUS;
        end
        else if (cmd_item.x_end == cmd_item.x_start)
        begin
            dcol    = '0;
            dir_col = DIR_NONE;
        end
        else
        begin
            dcol    = cmd_item.x_start - cmd_item.x_end;
            dir_col = DIR_MINUS;
        end

        if (cmd_item.y_end > cmd_item.y_start)
        begin
            drow    = cmd_item.y_end - cmd_item.y_start;
            dir_row = DIR_PLUS;
        end
        else if (cmd_item.y_end == cmd_item.y_start)
        begin
            drow    = '0;
            dir_row = DIR_NONE;
        end
        else
        begin
            drow    = cmd_item.y_start - cmd_item.y_end;
            dir_row = DIR_MINUS;
        end
    end

    always_comb
    begin
        push_op.is_load  = (cmd_item.cmd == CMD_LOAD);
        push_op.col      = cmd_item.x_start;
        push_op.row      = cmd_item.y_start;
        push_op.abs_dcol = dcol;
        push_op.abs_drow = drow;
        push_op.major    = (dcol > drow) ? dcol : drow;
        push_op.dir_col  = dir_col;
        push_op.dir_row  = dir_row;
        push_op.color    = cmd_item.pixel_color;
    end

    assign cmd_stall = qstat.full;
    assign push      = cmd_valid && !qstat.full;

endmodule
`default_nettype wire

@@ src/lps_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lps_queue: operation queue between front and back
// A small register FIFO that lets intake and stepping stall independently.
// ----------------------------------------------------------------------------
module lps_queue #(
    parameter int DEPTH = lps_pkg::QUEUE_DEPTH
) (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   push,
    input  lps_pkg::lps_op_t      push_op,
    input  wire                   pop,
    output lps_pkg::lps_op_t      head_op,
    output lps_pkg::lps_qstat_t   qstat
);
    import lps_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_QW = $clog2(DEPTH + 1);

    lps_op_t            slot_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_QW-1:0]  count_reg;
    logic [CNT_QW-1:0]  count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_QW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_QW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_op;
        end
    end

    assign head_op     = slot_reg[rd_ptr_reg];
    assign qstat.full  = (count_reg == CNT_QW'(DEPTH));
    assign qstat.empty = (count_reg == '0);

endmodule
`default_nettype wire

@@ src/lps_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lps_back: line stepper and pixel output register
// Executes queued loads and steps, advancing the error accumulators and
// presenting one pixel transaction per active step.
// ----------------------------------------------------------------------------
module lps_back (
    input  wire                   clk,
    input  wire                   rst_n,
    input  lps_pkg::lps_op_t      head_op,
    input  lps_pkg::lps_qstat_t   qstat,
    output logic                  pop,
    output logic                  pix_valid,
    input  wire                   pix_stall,
    output lps_pkg::pix_item_t    pix_item
);
    import lps_pkg::*;

    logic [COORD_W-1:0] cur_col_reg,  cur_col_next;
    logic [COORD_W-1:0] cur_row_reg,  cur_row_next;
    logic [ERR_W-1:0]   err_col_reg,  err_col_next;
    logic [ERR_W-1:0]   err_row_reg,  err_row_next;
    logic [COORD_W-1:0] abs_dcol_reg, abs_dcol_next;
    logic [COORD_W-1:0] abs_drow_reg, abs_drow_next;
    logic [COORD_W-1:0] major_reg,    major_next;
    dir_t               dir_col_reg,  dir_col_next;
    dir_t               dir_row_reg,  dir_row_next;
    logic [CNT_W-1:0]   left_reg,     left_next;
    logic [COLOR_W-1:0] color_reg,    color_next;
    logic               busy_reg,     busy_next;
    logic               pix_valid_reg, pix_valid_next;
    pix_item_t          pix_item_reg, pix_item_next;

    logic               out_free;
    logic               emit;
    logic [ERR_W-1:0]   col_sum;
    logic [ERR_W-1:0]   row_sum;
    logic               last;

    function automatic logic [COORD_W-1:0] axis_move(input logic [COORD_W-1:0] pos,
                                                     input dir_t dir);
        logic [COORD_W-1:0] res;
        case (dir)
            DIR_PLUS:  res = pos + COORD_W'(1);
            DIR_MINUS: res = pos - COORD_W'(1);
            default:   res = pos;
        endcase
        return res;
    endfunction

    assign out_free = !pix_valid_reg || !pix_stall;
    // Loads and idle steps make no pixel, so they never wait on the output.
    assign pop  = !qstat.empty && (head_op.is_load || !busy_reg || out_free);
    assign emit = pop && !head_op.is_load && busy_reg;

    assign col_sum = err_col_reg + {1'b0, abs_dcol_reg};
    assign row_sum = err_row_reg + {1'b0, abs_drow_reg};
    assign last    = (left_reg <= CNT_W'(1));

    always_comb
    begin
        cur_col_next  = cur_col_reg;
        cur_row_next  = cur_row_reg;
        err_col_next  = err_col_reg;
        err_row_next  = err_row_reg;
        abs_dcol_next = abs_dcol_reg;
        abs_drow_next = abs_drow_reg;
        major_next    = major_reg;
        dir_col_next  = dir_col_reg;
        dir_row_next  = dir_row_reg;
        left_next     = left_reg;
        color_next    = color_reg;
        busy_next     = busy_reg;

        if (pop && head_op.is_load)
        begin
            cur_col_next  = head_op.col;
            cur_row_next  = head_op.row;
            err_col_next  = '0;
            err_row_next  = '0;
            abs_dcol_next = head_op.abs_dcol;
            abs_drow_next = head_op.abs_drow;
            major_next    = head_op.major;
            dir_col_next  = head_op.dir_col;
            dir_row_next  = head_op.dir_row;
            left_next     = {1'b0, head_op.major} + CNT_W'(2);
            color_next    = head_op.color;
            busy_next     = 1'b1;
        end
        else if (emit)
        begin
            err_col_next = col_sum;
            err_row_next = row_sum;
            if (col_sum > {1'b0, major_reg})
            begin
                err_col_next = col_sum - {1'b0, major_reg};
                cur_col_next = axis_move(cur_col_reg, dir_col_reg);
            end
            if (row_sum > {1'b0, major_reg})
            begin
                err_row_next = row_sum - {1'b0, major_reg};
                cur_row_next = axis_move(cur_row_reg, dir_row_reg);
            end
            if (last)
            begin
                left_next = '0;
                busy_next = 1'b0;
            end
            else
            begin
                left_next = left_reg - CNT_W'(1);
            end
        end
    end

    always_comb
    begin
        pix_item_next = pix_item_reg;
        if (emit)
        begin
            pix_valid_next            = 1'b1;
            pix_item_next.point_x     = cur_col_reg;
            pix_item_next.point_y     = cur_row_reg;
            pix_item_next.pix_color   = color_reg;
            pix_item_next.last_point  = last;
        end
        else
        begin
            pix_valid_next = pix_valid_reg && pix_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_col_reg   <= '0;
            cur_row_reg   <= '0;
            err_col_reg   <= '0;
            err_row_reg   <= '0;
            abs_dcol_reg  <= '0;
            abs_drow_reg  <= '0;
            major_reg     <= '0;
            dir_col_reg   <= DIR_NONE;
            dir_row_reg   <= DIR_NONE;
            left_reg      <= '0;
            color_reg     <= '0;
            busy_reg      <= 1'b0;
            pix_valid_reg <= 1'b0;
        end
        else
        begin
            cur_col_reg   <= cur_col_next;
            cur_row_reg   <= cur_row_next;
            err_col_reg   <= err_col_next;
            err_row_reg   <= err_row_next;
            abs_dcol_reg  <= abs_dcol_next;
            abs_drow_reg  <= abs_drow_next;
            major_reg     <= major_next;
            dir_col_reg   <= dir_col_next;
            dir_row_reg   <= dir_row_next;
            left_reg      <= left_next;
            color_reg     <= color_next;
            busy_reg      <= busy_next;
            pix_valid_reg <= pix_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pix_item_reg <= pix_item_next;
    end

    assign pix_valid = pix_valid_reg;
    assign pix_item  = pix_item_reg;

`ifndef ASSERT_OFF
    a_busy_has_points: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (left_reg != '0))
        else $error("active line with no points left");

    a_err_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
        err_col_reg <= {1'b0, major_reg})
        else $error("column error exceeds major distance");

    a_err_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
        err_row_reg <= {1'b0, major_reg})
        else $error("row error exceeds major distance");

    a_last_ends_line: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && last && !(qstat.empty)) |=> !busy_reg)
        else $error("line still active after its last point");
`endif

endmodule
`default_nettype wire

@@ bench/lps_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lps_checker: pixel stream scoreboard for the line point stepper
// Watches both channels, runs its own error-accumulation line predictor on
// every accepted command transaction and compares each accepted pixel with the
// oldest predicted one.
// ----------------------------------------------------------------------------
module lps_checker (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 cmd_valid,
    input  wire                 cmd_stall,
    input  lps_pkg::cmd_item_t  cmd_item,
    input  wire                 pix_valid,
    input  wire                 pix_stall,
    input  lps_pkg::pix_item_t  pix_item,
    output int                  fail_count,
    output int                  pending,
    output int                  line_count,
    output int                  point_count,
    output int                  last_count
);
    import lps_pkg::*;

    localparam int ACC_W = COORD_W + 2;

    logic [COORD_W-1:0] pos_col;
    logic [COORD_W-1:0] pos_row;
    logic [COORD_W-1:0] dlt_col;
    logic [COORD_W-1:0] dlt_row;
    logic [COORD_W-1:0] span;
    logic [ACC_W-1:0]   acc_col;
    logic [ACC_W-1:0]   acc_row;
    dir_t               step_col;
    dir_t               step_row;
    logic [CNT_W-1:0]   remaining;
    logic [COLOR_W-1:0] ink;
    logic               drawing;
    pix_item_t          pixel_fifo[$];

    task automatic axis_span(input logic [COORD_W-1:0] from, input logic [COORD_W-1:0] to,
                             output logic [COORD_W-1:0] delta, output dir_t way);
        if (to > from)
        begin
            delta = to - from;
            way   = DIR_PLUS;
        end
        else if (to == from)
        begin
            delta = '0;
            way   = DIR_NONE;
        end
        else
        begin
            delta = from - to;
            way   = DIR_MINUS;
        end
    endtask

    function automatic logic [COORD_W-1:0] nudge(input logic [COORD_W-1:0] p, input dir_t way);
        case (way)
            DIR_PLUS:  return p + 1'b1;
            DIR_MINUS: return p - 1'b1;
            default:   return p;
        endcase
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        pix_item_t want;
        if (!rst_n)
        begin
            pos_col     = '0;
            pos_row     = '0;
            dlt_col     = '0;
            dlt_row     = '0;
            span        = '0;
            acc_col     = '0;
            acc_row     = '0;
            step_col    = DIR_NONE;
            step_row    = DIR_NONE;
            remaining   = '0;
            ink         = '0;
            drawing     = 1'b0;
            pixel_fifo.delete();
            fail_count  = 0;
            pending     = 0;
            line_count  = 0;
            point_count = 0;
            last_count  = 0;
        end
        else
        begin
            // Compare before predicting, so a spurious pixel can never pair up
            // with a step accepted at the same edge.
            if (pix_valid && !pix_stall)
            begin
                if (pixel_fifo.size() == 0)
                begin
                    $error("unexpected pixel transaction: x=%0d y=%0d color=%0h last=%0b",
                           pix_item.point_x, pix_item.point_y, pix_item.pix_color,
                           pix_item.last_point);
                    fail_count++;
                end
                else
                begin
                    want = pixel_fifo.pop_front();
                    check_field("point_x", 32'(want.point_x), 32'(pix_item.point_x));
                    check_field("point_y", 32'(want.point_y), 32'(pix_item.point_y));
                    check_field("pix_color", 32'(want.pix_color),
                                32'(pix_item.pix_color));
                    check_field("last_point", 32'(want.last_point), 32'(pix_item.last_point));
                    point_count++;
                    if (want.last_point)
                        last_count++;
                end
            end

            if (cmd_valid && !cmd_stall)
            begin
                if (cmd_item.cmd == CMD_LOAD)
                begin
                    axis_span(cmd_item.x_start, cmd_item.x_end, dlt_col, step_col);
                    axis_span(cmd_item.y_start, cmd_item.y_end, dlt_row, step_row);
                    span      = (dlt_col > dlt_row) ? dlt_col : dlt_row;
                    pos_col   = cmd_item.x_start;
                    pos_row   = cmd_item.y_start;
                    acc_col   = '0;
                    acc_row   = '0;
                    ink       = cmd_item.pixel_color;
                    remaining = CNT_W'(span) + CNT_W'(2);
                    drawing   = 1'b1;
                    line_count++;
                end
                else if (drawing)
                begin
                    want.point_x     = pos_col;
                    want.point_y     = pos_row;
                    want.pix_color   = ink;
                    want.last_point  = (remaining <= 1);
                    pixel_fifo.push_back(want);

                    acc_col = acc_col + ACC_W'(dlt_col);
                    acc_row = acc_row + ACC_W'(dlt_row);
                    if (acc_col > ACC_W'(span))
                    begin
                        acc_col = acc_col - ACC_W'(span);
                        pos_col = nudge(pos_col, step_col);
                    end
                    if (acc_row > ACC_W'(span))
                    begin
                        acc_row = acc_row - ACC_W'(span);
                        pos_row = nudge(pos_row, step_row);
                    end

                    if (remaining <= 1)
                    begin
                        remaining = '0;
                        drawing   = 1'b0;
                    end
                    else
                        remaining = remaining - 1'b1;
                end
            end
            pending = pixel_fifo.size();
        end
    end

endmodule
`default_nettype wire

@@ bench/tb_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top: testbench for the line point stepper core
// Drives directed and random line loads and steps with random idle bursts on
// both channels, a long output hold and a drain pause, and reports the verdict
// from the scoreboard's failure count.
// ----------------------------------------------------------------------------
module tb_top;
    import lps_pkg::*;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int HOLD_CYCLES  = 300;
    localparam int RANDOM_ITEMS = 500;
    localparam int QUIET_TAIL   = 80;
    localparam int COORD_MAX    = (1 << COORD_W) - 1;

    logic      clk;
    logic      rst_n;
    logic      cmd_valid;
    logic      cmd_stall;
    cmd_item_t cmd_item;
    logic      pix_valid;
    logic      pix_stall;
    pix_item_t pix_item;

    int fail_count;
    int pending;
    int line_count;
    int point_count;
    int last_count;

    int cycles;
    int hold_requests;
    bit quiet;
    int live_points;
    int issued;

    line_point_stepper_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_item  (cmd_item),
        .pix_valid (pix_valid),
        .pix_stall (pix_stall),
        .pix_item  (pix_item)
    );

    lps_checker scoreboard (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_stall   (cmd_stall),
        .cmd_item    (cmd_item),
        .pix_valid   (pix_valid),
        .pix_stall   (pix_stall),
        .pix_item    (pix_item),
        .fail_count  (fail_count),
        .pending     (pending),
        .line_count  (line_count),
        .point_count (point_count),
        .last_count  (last_count)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles with %0d pixels outstanding.", cycles, pending);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Pixel receiver: random stall bursts, plus one long hold on request.
    initial
    begin : pixel_sink
        int stall_left;
        int hold_seen;
        stall_left = 0;
        hold_seen  = 0;
        pix_stall  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_requests != hold_seen)
            begin
                hold_seen  = hold_requests;
                stall_left = HOLD_CYCLES;
            end
            else if (stall_left == 0 && !quiet && $urandom_range(0, 9) == 0)
                stall_left = $urandom_range(1, 12);
            if (stall_left > 0)
            begin
                pix_stall <= 1'b1;
                stall_left--;
            end
            else
                pix_stall <= 1'b0;
        end
    end

    function automatic cmd_item_t random_payload();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[$bits(cmd_item_t)-1:0];
    endfunction

    function automatic int line_points(input cmd_item_t it);
        int dc;
        int dr;
        dc = int'(it.x_end) - int'(it.x_start);
        dr = int'(it.y_end) - int'(it.y_start);
        if (dc < 0)
            dc = -dc;
        if (dr < 0)
            dr = -dr;
        return ((dc > dr) ? dc : dr) + 2;
    endfunction

    function automatic logic [COORD_W-1:0] near(input logic [COORD_W-1:0] c, input int reach);
        int v;
        v = int'(c) + int'($urandom_range(0, 2 * reach)) - reach;
        if (v < 0)
            v = 0;
        if (v > COORD_MAX)
            v = COORD_MAX;
        return v[COORD_W-1:0];
    endfunction

    // Offers one command transaction and returns once it has been accepted.
    task automatic send_cmd(input cmd_item_t it);
        int gap;
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 12);
            @(negedge clk);
            cmd_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        cmd_valid <= 1'b1;
        cmd_item  <= it;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        if (it.cmd == CMD_LOAD)
        begin
            live_points = line_points(it);
            issued++;
        end
        else if (live_points > 0)
        begin
            live_points--;
            issued++;
        end
    endtask

    task automatic send_step();
        cmd_item_t it;
        it     = random_payload();
        it.cmd = CMD_STEP;
        send_cmd(it);
    endtask

    task automatic load_line(input int xs, input int ys, input int xe, input int ye,
                             input int color);
        cmd_item_t it;
        it             = random_payload();
        it.cmd         = CMD_LOAD;
        it.x_start     = xs[COORD_W-1:0];
        it.y_start     = ys[COORD_W-1:0];
        it.x_end       = xe[COORD_W-1:0];
        it.y_end       = ye[COORD_W-1:0];
        it.pixel_color = color[COLOR_W-1:0];
        send_cmd(it);
    endtask

    task automatic hold_until_drained();
        @(negedge clk);
        cmd_valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
    endtask

    // A load followed mostly by exactly the steps the line needs; sometimes
    // it oversteps into idle, sometimes the next load cuts it short.
    task automatic random_line();
        cmd_item_t it;
        int pick;
        int reach;
        int pts;
        int steps;
        it   = random_payload();
        it.cmd = CMD_LOAD;
        pick = $urandom_range(0, 99);
        if (pick >= 3)
        begin
            reach    = (pick < 20) ? 127 : 12;
            it.x_end = near(it.x_start, reach);
            it.y_end = near(it.y_start, reach);
        end
        pick = $urandom_range(0, 9);
        if (pick == 0)
            it.x_end = it.x_start;
        else if (pick == 1)
            it.y_end = it.y_start;
        pts = line_points(it);
        send_cmd(it);
        pick = $urandom_range(0, 99);
        if (pick < 70)
            steps = pts;
        else if (pick < 85)
            steps = pts + $urandom_range(1, 3);
        else
            steps = $urandom_range(0, pts - 1);
        repeat (steps) send_step();
    endtask

    initial
    begin : stimulus
        int target;
        cycles        = 0;
        hold_requests = 0;
        quiet         = 1'b0;
        live_points   = 0;
        issued        = 0;
        cmd_valid     = 1'b0;
        cmd_item      = '0;
        rst_n         = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: a step with no line, a zero-length line run past its end,
        // an extreme diagonal replaced mid-line, and a steep line in the
        // minus direction on both axes.
        send_step();
        load_line(0, 0, 0, 0, 16'hFFFF);
        repeat (3) send_step();
        load_line(COORD_MAX, COORD_MAX, 0, 0, 16'h0000);
        repeat (3) send_step();
        load_line(0, COORD_MAX, COORD_MAX, 0, 16'hA5A5);
        repeat (2) send_step();
        load_line(3, 9, 0, 2, 16'h5A5A);
        repeat (10) send_step();

        // Output held off while steps keep coming, so the core backs up.
        load_line(100, 200, 160, 230, 16'h07E0);
        hold_requests++;
        repeat (61) send_step();
        hold_until_drained();

        target = issued + RANDOM_ITEMS;
        while (issued < target)
        begin
            if (issued >= target - QUIET_TAIL)
                quiet = 1'b1;
            if ($urandom_range(0, 99) < 5)
                send_cmd(random_payload());
            else
                random_line();
        end

        hold_until_drained();
        repeat (8) @(posedge clk);
        $display("Checked %0d pixels over %0d line loads, %0d of them closing a line.",
                 point_count, line_count, last_count);
        $display("Included a %0d-cycle output hold with input back-pressure and a drain pause.",
                 HOLD_CYCLES);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
`default_nettype wire

@@ sim.f @@
src/lps_pkg.sv
src/lps_front.sv
src/lps_queue.sv
src/lps_back.sv
src/line_point_stepper_core.sv
bench/lps_checker.sv
bench/tb_top.sv
